[design/sblr_pkg.sv]
package sblr_pkg;

   // Window geometry
   localparam int MAX_RADIUS = 63;
   localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
   localparam int RP1_W      = RAD_W + 1;
   localparam int SQ_W       = 2 * RAD_W + 1;

   // Pixel layout: red, green, blue, alpha from the lowest byte up
   localparam int CH_W   = 8;
   localparam int NUM_CH = 4;
   localparam int PIX_W  = CH_W * NUM_CH;

   // Accumulator widths
   localparam int SUM_W  = CH_W + RAD_W;
   localparam int WS_W   = CH_W + 2 * RAD_W;

   // Output scaling
   localparam int MUL_W   = 10;
   localparam int SHIFT_W = 5;
   localparam int PROD_W  = WS_W + MUL_W;

   // Pixel count within a line, saturating
   localparam int SEEN_W = 7;
   localparam logic [SEEN_W-1:0] SEEN_CAP = '1;

   // Register file
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = MUL_W;
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS      = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_MUL   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_SHIFT = CSR_IDX_W'(2);

   localparam logic [RAD_W-1:0]   RADIUS_RST = RAD_W'(1);
   localparam logic [SQ_W-1:0]    SQ_RST     = SQ_W'(4);
   localparam logic [MUL_W-1:0]   MUL_RST    = MUL_W'(512);
   localparam logic [SHIFT_W-1:0] SHIFT_RST  = SHIFT_W'(11);

   // Window cell control
   typedef struct packed {
      logic fill;   // load every cell with the line's first pixel
      logic shift;  // move one place toward the chain exit
   } cell_ctl_type;

   // Per-channel accumulator control
   typedef struct packed {
      logic fill;   // initialize sums for a window of one repeated pixel
      logic push;   // slide the window by one pixel
      logic mul;    // scale the weighted sum
   } lane_ctl_type;

endpackage

[design/sblr_cell.sv]
module sblr_cell
   import sblr_pkg::*;
(
   input  logic             clock,
   input  cell_ctl_type     ctl,
   input  logic             inject,
   input  logic [PIX_W-1:0] new_pix,
   input  logic [PIX_W-1:0] up_pix,
   output logic [PIX_W-1:0] pix
);

   logic [PIX_W-1:0] pix_ff;
   logic [PIX_W-1:0] pix_in;

   // A fill loads the new pixel; a shift takes the neighbor or the injected pixel
   always_comb begin
      pix_in = pix_ff;
      if (ctl.fill) begin
         pix_in = new_pix;
      end else if (ctl.shift) begin
         pix_in = inject ? new_pix : up_pix;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
   end

   assign pix = pix_ff;

endmodule

[design/sblr_chain.sv]
module sblr_chain
   import sblr_pkg::*;
(
   input  logic             clock,
   input  cell_ctl_type     ctl,
   input  logic [RAD_W-1:0] len,
   input  logic [PIX_W-1:0] feed,
   output logic [PIX_W-1:0] tail
);

   // Cell 0 is the exit. A pixel enters at cell len-1, so it leaves after len shifts.
   logic [PIX_W-1:0] cell_pix [MAX_RADIUS];

   for (genvar i = 0; i < MAX_RADIUS; i++) begin : g_cell
      logic             inject;
      logic [PIX_W-1:0] up_pix;

      assign inject = (len == RAD_W'(i + 1));

      if (i == MAX_RADIUS - 1) begin : g_top
         assign up_pix = feed;
      end else begin : g_mid
         assign up_pix = cell_pix[i + 1];
      end

      sblr_cell u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .inject  (inject),
         .new_pix (feed),
         .up_pix  (up_pix),
         .pix     (cell_pix[i])
      );
   end

   assign tail = cell_pix[0];

endmodule

[design/sblr_lane.sv]
module sblr_lane
   import sblr_pkg::*;
(
   input  logic               clock,
   input  lane_ctl_type       ctl,
   input  logic [CH_W-1:0]    x,            // incoming pixel
   input  logic [CH_W-1:0]    a_in,         // pixel becoming the center
   input  logic [CH_W-1:0]    c_in,         // current center
   input  logic [CH_W-1:0]    b_in,         // oldest pixel, leaving the window
   input  logic [RP1_W-1:0]   rp1,          // radius + 1
   input  logic [SQ_W-1:0]    sq,           // (radius + 1)^2
   input  logic [MUL_W-1:0]   scale_mul,
   input  logic [SHIFT_W-1:0] scale_shift,
   output logic [CH_W-1:0]    result
);

   logic [SUM_W-1:0]  sin_ff, sin_in;    // newest r+1 pixels, center included
   logic [SUM_W-1:0]  sout_ff, sout_in;  // oldest r+1 pixels, center included
   logic [WS_W-1:0]   ws_ff, ws_in;      // triangular weighted sum
   logic [PROD_W-1:0] prod_ff;

   // Running sums: a fill starts from one repeated pixel, a push slides by one
   always_comb begin
      sin_in  = sin_ff;
      sout_in = sout_ff;
      ws_in   = ws_ff;
      if (ctl.fill) begin
         sin_in  = SUM_W'(x) * SUM_W'(rp1);
         sout_in = SUM_W'(x) * SUM_W'(rp1);
         ws_in   = WS_W'(x) * WS_W'(sq);
      end else if (ctl.push) begin
         sin_in  = sin_ff + SUM_W'(x) - SUM_W'(c_in);
         sout_in = sout_ff + SUM_W'(a_in) - SUM_W'(b_in);
         ws_in   = ws_ff + WS_W'(sin_in) - WS_W'(sout_ff);
      end
   end

   always_ff @(posedge clock) begin
      sin_ff  <= sin_in;
      sout_ff <= sout_in;
      ws_ff   <= ws_in;
      if (ctl.mul) begin
         prod_ff <= PROD_W'(ws_ff) * PROD_W'(scale_mul);
      end
   end

   // Low byte of the shifted product
   assign result = CH_W'(prod_ff >> scale_shift);

endmodule

[design/stack_blur_line_rgba_core.sv]
// One-dimensional stack blur over a line of RGBA pixels, 8 bits per channel, with
// triangular weights over 2r+1 pixels and the edge pixels repeated past either end.
// Each channel's result is (weighted_sum * scale_mul) >> scale_shift, low 8 bits.
// Pixel k of a line yields blurred pixel k-r; the beat with req_tlast also emits the
// rest of the line, the final one marked with rsp_tlast. The radius is sampled at a
// line's first pixel; scale_mul and scale_shift when each result is formed. Program
// registers only while the block is idle. A pixel that yields a result passes through
// accept and window update, the per-channel multiply and the output register load,
// the last step waiting while the output register is still full; a pixel that yields
// no result is only accepted. No new pixel is taken until the block is idle again.
// After a line's last pixel the block replays it r times, and a replay that yields a
// result forms it in the same way. No clearing pass is needed after reset.
module stack_blur_line_rgba_core
   import sblr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Pixel input
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIX_W-1:0]      req_tdata,    // in_red, in_green, in_blue, in_alpha
   input  logic                  req_tlast,    // last_in_line
   // Blurred pixel output
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PIX_W-1:0]      rsp_tdata,    // out_red, out_green, out_blue, out_alpha
   output logic                  rsp_tlast,    // last_out
   // Register writes
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_OUT,
      ST_PUSH
   } state_type;

   state_type          state_ff, state_in;
   logic               line_start_ff, line_start_in;
   logic [RAD_W-1:0]   lr_ff, lr_in;           // radius of the current line
   logic [SEEN_W-1:0]  seen_ff, seen_in;
   logic [RAD_W-1:0]   kcnt_ff, kcnt_in;       // replays done at line end
   logic               line_last_ff, line_last_in;
   logic               pend_last_ff, pend_last_in;
   logic [PIX_W-1:0]   hold_ff, hold_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]   rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [RAD_W-1:0]   radius_ff, radius_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [MUL_W-1:0]   mul_ff, mul_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;

   logic               accept;
   logic               do_fill;
   logic               do_push;
   logic               rsp_free;
   logic [SEEN_W-1:0]  seen_inc;
   logic [RP1_W-1:0]   wr_rp1;
   logic [RP1_W-1:0]   rp1;
   logic [PIX_W-1:0]   cur_pix;
   logic [PIX_W-1:0]   a_tail, b_tail, c_pix;
   logic [PIX_W-1:0]   a_out, b_out;
   logic [PIX_W-1:0]   c_feed, b_feed;
   logic [PIX_W-1:0]   lane_res;
   cell_ctl_type       cell_ctl;
   cell_ctl_type       c_ctl;
   lane_ctl_type       lane_ctl;

   // Handshake and window control
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign do_fill    = accept && line_start_ff;
   assign do_push    = (accept && !line_start_ff) || (state_ff == ST_PUSH);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign seen_inc   = (seen_ff == SEEN_CAP) ? seen_ff : seen_ff + SEEN_W'(1);
   assign cur_pix    = (state_ff == ST_PUSH) ? hold_ff : req_tdata;
   assign rp1        = RP1_W'(radius_ff) + RP1_W'(1);
   assign wr_rp1     = RP1_W'(csr_wr_data[RAD_W-1:0]) + RP1_W'(1);

   assign cell_ctl = '{fill: do_fill, shift: do_push};
   assign c_ctl    = cell_ctl;
   assign lane_ctl = '{fill: do_fill, push: do_push, mul: (state_ff == ST_MUL)};

   // With radius zero the two chains are empty and the taps fall through
   assign a_out  = (lr_ff == '0) ? cur_pix : a_tail;
   assign b_out  = (lr_ff == '0) ? c_pix : b_tail;
   assign c_feed = do_fill ? cur_pix : a_out;
   assign b_feed = do_fill ? cur_pix : c_pix;

   // Newer half of the window: s[0..r-1]
   sblr_chain u_chain_a (
      .clock (clock),
      .ctl   (cell_ctl),
      .len   (lr_ff),
      .feed  (cur_pix),
      .tail  (a_tail)
   );

   // Center pixel s[r]
   sblr_cell u_center (
      .clock   (clock),
      .ctl     (c_ctl),
      .inject  (1'b1),
      .new_pix (c_feed),
      .up_pix  (c_feed),
      .pix     (c_pix)
   );

   // Older half of the window: s[r+1..2r]
   sblr_chain u_chain_b (
      .clock (clock),
      .ctl   (cell_ctl),
      .len   (lr_ff),
      .feed  (b_feed),
      .tail  (b_tail)
   );

   // One accumulator lane per channel
   for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
      sblr_lane u_lane (
         .clock       (clock),
         .ctl         (lane_ctl),
         .x           (cur_pix[ch*CH_W +: CH_W]),
         .a_in        (a_out[ch*CH_W +: CH_W]),
         .c_in        (c_pix[ch*CH_W +: CH_W]),
         .b_in        (b_out[ch*CH_W +: CH_W]),
         .rp1         (rp1),
         .sq          (sq_ff),
         .scale_mul   (mul_ff),
         .scale_shift (shift_ff),
         .result      (lane_res[ch*CH_W +: CH_W])
      );
   end

   // Sequencer, output register and register file
   always_comb begin
      state_in      = state_ff;
      line_start_in = line_start_ff;
      lr_in         = lr_ff;
      seen_in       = seen_ff;
      kcnt_in       = kcnt_ff;
      line_last_in  = line_last_ff;
      pend_last_in  = pend_last_ff;
      hold_in       = hold_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      radius_in     = radius_ff;
      sq_in         = sq_ff;
      mul_in        = mul_ff;
      shift_in      = shift_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               hold_in      = req_tdata;
               line_last_in = req_tlast;
               kcnt_in      = '0;
               if (line_start_ff) begin
                  lr_in         = radius_ff;
                  seen_in       = SEEN_W'(1);
                  line_start_in = 1'b0;
               end else begin
                  seen_in = seen_inc;
               end
               pend_last_in = req_tlast && (lr_in == '0);
               if (seen_in > SEEN_W'(lr_in)) begin
                  state_in = ST_MUL;
               end else if (req_tlast) begin
                  state_in = ST_PUSH;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = lane_res;
               rsp_last_in  = pend_last_ff;
               if (line_last_ff && (kcnt_ff != lr_ff)) begin
                  state_in = ST_PUSH;
               end else begin
                  state_in = ST_IDLE;
                  if (line_last_ff) begin
                     line_start_in = 1'b1;
                     seen_in       = '0;
                  end
               end
            end
         end
         ST_PUSH: begin
            kcnt_in      = kcnt_ff + RAD_W'(1);
            seen_in      = seen_inc;
            pend_last_in = (kcnt_in == lr_ff);
            if (seen_in > SEEN_W'(lr_ff)) begin
               state_in = ST_MUL;
            end else if (kcnt_in == lr_ff) begin
               state_in      = ST_IDLE;
               line_start_in = 1'b1;
               seen_in       = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         unique case (csr_index)
            REG_RADIUS: begin
               radius_in = csr_wr_data[RAD_W-1:0];
               sq_in     = SQ_W'(wr_rp1) * SQ_W'(wr_rp1);
            end
            REG_SCALE_MUL: begin
               mul_in = csr_wr_data[MUL_W-1:0];
            end
            REG_SCALE_SHIFT: begin
               shift_in = csr_wr_data[SHIFT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         line_start_ff <= 1'b1;
         lr_ff         <= RADIUS_RST;
         seen_ff       <= '0;
         kcnt_ff       <= '0;
         line_last_ff  <= 1'b0;
         pend_last_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         radius_ff     <= RADIUS_RST;
         sq_ff         <= SQ_RST;
         mul_ff        <= MUL_RST;
         shift_ff      <= SHIFT_RST;
      end else begin
         state_ff      <= state_in;
         line_start_ff <= line_start_in;
         lr_ff         <= lr_in;
         seen_ff       <= seen_in;
         kcnt_ff       <= kcnt_in;
         line_last_ff  <= line_last_in;
         pend_last_ff  <= pend_last_in;
         rsp_valid_ff  <= rsp_valid_in;
         radius_ff     <= radius_in;
         sq_ff         <= sq_in;
         mul_ff        <= mul_in;
         shift_ff      <= shift_in;
      end
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[design/sblr_checker.sv]
module sblr_checker
   import sblr_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             req_tlast,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [PIX_W-1:0] rsp_tdata,
   input logic             rsp_tlast
);

   // A stalled output beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("output beat changed while stalled");

   // Output is empty right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

   // A result is loaded only while the input side is closed
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared while input was open");

   // The last pixel of a line always starts work that closes the input
   a_flush_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input open right after the last pixel of a line");

endmodule

bind stack_blur_line_rgba_core sblr_checker u_sblr_checker (.*);
